// ----- hdl/kmce_pkg.sv -----
package kmce_pkg;

  localparam int ROW_W    = 3;
  localparam int BITS_W   = 6;
  localparam int MAPCOL_W = 3;
  localparam int CODE_W   = 8;
  localparam int COL_IDX_W = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_MAP  = 1'b1
  } opcode_t;

  function automatic logic [COL_IDX_W-1:0] lowest_set(input logic [BITS_W-1:0] v);
    logic [COL_IDX_W-1:0] idx;
    idx = '0;
    for (int i = BITS_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = COL_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- hdl/kmce_clr_ram.sv -----
module kmce_clr_ram #(
  parameter int DEPTH  = 10,
  parameter int WIDTH  = 6,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("read and write of the same entry in one cycle");

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (32'(wr_addr) < DEPTH))
    else $error("write address beyond depth");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (32'(rd_addr) < DEPTH))
    else $error("read address beyond depth");

endmodule

// ----- hdl/key_matrix_change_encoder.sv -----
// Key matrix change encoder for a split keyboard.
// s_* channel: one word per scanned row (s_tuser = 0) or per keymap write
// (s_tuser = 1). A scan word is compared with the stored bits of its row;
// every changed column, lowest first, yields one m_* word carrying the mapped
// key code and the new key level (m_tuser, 1 = down); m_tlast marks the final
// word of that scan. A scan with no change, and any keymap write, yields none.
// Words whose half, row or keymap column is out of range are dropped.
// Timing: a keymap write is done at its handshake and leaves s_tready high. A scan
// first reads the previous row state, then issues one keymap read per event,
// pipelined one per cycle through the output register while m_tready does not
// stall it. The first result word passes the row read, the keymap read and the
// output register; s_tready comes back in the cycle after the last result word is loaded.
// Reset: row states and keymap read as zero (all keys up, all codes zero)
// through per-entry valid flags, so there is no clearing pass and words are
// taken right after reset.
// Stall: while m_tready is low the result word holds and event emission waits
// on the pending keymap read; no word is lost.
module key_matrix_change_encoder
  import kmce_pkg::*;
#(
  parameter int ROW_COUNT    = 5,
  parameter int COLUMN_COUNT = 6,
  parameter int HALF_COUNT   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // half, row[2:0], column_bits[5:0], map_column[2:0], map_code[7:0]
  input  logic        s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // key_code[7:0]
  output logic        m_tuser,  // pressed
  output logic        m_tlast
);

  localparam int ROW_SLOTS = HALF_COUNT * ROW_COUNT;
  localparam int KEY_SLOTS = ROW_SLOTS * COLUMN_COUNT;
  localparam int SLOT_W    = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int KEY_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int NCOL      = (COLUMN_COUNT < BITS_W) ? COLUMN_COUNT : BITS_W;
  localparam logic [BITS_W-1:0] COL_MASK = BITS_W'((1 << NCOL) - 1);

  logic                in_half;
  logic [ROW_W-1:0]    in_row;
  logic [BITS_W-1:0]   in_bits;
  logic [MAPCOL_W-1:0] in_mcol;
  logic [CODE_W-1:0]   in_code;
  opcode_t             in_op;
  logic                in_ok;
  logic [SLOT_W-1:0]   in_slot;
  logic                accept;
  logic                scan_go;

  state_t              state;
  state_t              state_next;
  logic [SLOT_W-1:0]   slot;
  logic [BITS_W-1:0]   cur_bits;
  logic [BITS_W-1:0]   diff;
  logic [BITS_W-1:0]   diff_next;
  logic                pend_pressed;
  logic                pend_last;

  logic [BITS_W-1:0]    row_rd;
  logic [BITS_W-1:0]    diff_c;
  logic [BITS_W-1:0]    src;
  logic [BITS_W-1:0]    rest;
  logic [COL_IDX_W-1:0] col;
  logic                 issue;
  logic                 load_out;
  logic                 key_we;
  logic [KEY_W-1:0]     key_waddr;
  logic [KEY_W-1:0]     key_raddr;
  logic [CODE_W-1:0]    key_rd;

  logic [CODE_W-1:0]    out_code;
  logic                 out_pressed;
  logic                 out_last;

  assign in_half = s_tdata[0];
  assign in_row  = s_tdata[3:1];
  assign in_bits = s_tdata[9:4];
  assign in_mcol = s_tdata[12:10];
  assign in_code = s_tdata[20:13];
  assign in_op   = opcode_t'(s_tuser);

  assign in_ok   = (32'(in_half) < HALF_COUNT) && (32'(in_row) < ROW_COUNT);
  assign in_slot = SLOT_W'(32'(in_half) * ROW_COUNT + 32'(in_row));

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign scan_go  = accept && (in_op == OP_SCAN) && in_ok;

  assign key_we    = accept && (in_op == OP_MAP) && in_ok && (32'(in_mcol) < COLUMN_COUNT);
  assign key_waddr = KEY_W'(32'(in_slot) * COLUMN_COUNT + 32'(in_mcol));

  kmce_clr_ram #(
    .DEPTH (ROW_SLOTS),
    .WIDTH (BITS_W)
  ) u_rows (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (scan_go),
    .rd_addr (in_slot),
    .rd_data (row_rd),
    .wr_en   (state == ST_LOAD),
    .wr_addr (slot),
    .wr_data (cur_bits)
  );

  kmce_clr_ram #(
    .DEPTH (KEY_SLOTS),
    .WIDTH (CODE_W)
  ) u_keymap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (issue),
    .rd_addr (key_raddr),
    .rd_data (key_rd),
    .wr_en   (key_we),
    .wr_addr (key_waddr),
    .wr_data (in_code)
  );

  assign diff_c    = (row_rd ^ cur_bits) & COL_MASK;
  assign src       = (state == ST_LOAD) ? diff_c : diff;
  assign col       = lowest_set(src);
  assign rest      = src & ~(BITS_W'(1) << col);
  assign key_raddr = KEY_W'(32'(slot) * COLUMN_COUNT + 32'(col));
  assign load_out  = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    diff_next  = diff;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (scan_go) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (src != '0) begin
          issue      = 1'b1;
          diff_next  = rest;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          if (pend_last) begin
            state_next = ST_IDLE;
          end else begin
            issue     = 1'b1;
            diff_next = rest;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        diff_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      diff     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      diff  <= diff_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_go) begin
      slot     <= in_slot;
      cur_bits <= in_bits & COL_MASK;
    end
    if (issue) begin
      pend_pressed <= cur_bits[col];
      pend_last    <= (rest == '0);
    end
    if (load_out) begin
      out_code    <= key_rd;
      out_pressed <= pend_pressed;
      out_last    <= pend_last;
    end
  end

  assign m_tdata = out_code;
  assign m_tuser = out_pressed;
  assign m_tlast = out_last;

  a_diff_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EMIT) |-> (diff == '0))
    else $error("pending changes outside emission");

  a_scan_load: assert property (@(posedge clk) disable iff (rst)
    scan_go |=> (state == ST_LOAD))
    else $error("scan word did not start a row read");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (load_out && pend_last) |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("final event did not close the scan");

  a_more_events: assert property (@(posedge clk) disable iff (rst)
    (load_out && !pend_last) |=> (state == ST_EMIT) && m_tvalid && !m_tlast)
    else $error("emission stopped before the final event");

endmodule

// ----- sim/key_matrix_change_encoder_tb.sv -----
module key_matrix_change_encoder_tb;
  import kmce_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS       = 5;
  localparam int COLS       = 6;
  localparam int HALVES     = 2;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    opcode_t     op;
    logic        half;
    logic [2:0]  row;
    logic [5:0]  bits;
    logic [2:0]  mcol;
    logic [7:0]  code;
  } key_word_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       pressed;
    logic       last;
  } key_change_t;

  // typed_count < 0: expectation comes from the predictor
  typedef struct {
    key_word_t   w;
    int          typed_count;
    logic [7:0]  typed_code;
    logic        typed_pressed;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;  // half, row[2:0], column_bits[5:0], map_column[2:0], map_code[7:0]
  logic        s_tuser;  // opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;  // key_code[7:0]
  logic        m_tuser;  // pressed
  logic        m_tlast;

  logic [5:0]  row_state [HALVES*ROWS];
  logic [7:0]  key_codes [HALVES*ROWS*COLS];
  key_change_t pending_changes[$];
  stim_row_t   stim_rows[$];

  int errors = 0;
  int words_sent;
  int changes_seen = 0;
  int send_idle;
  int recv_idle;
  int stall_cnt = 0;
  bit hold_req;
  bit hold_done;

  key_matrix_change_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t stim(opcode_t op, logic half, logic [2:0] row, logic [5:0] bits,
                                     logic [2:0] mcol, logic [7:0] code, int n,
                                     logic [7:0] tcode, logic tpressed);
    stim_row_t r;
    r.w = '{op: op, half: half, row: row, bits: bits, mcol: mcol, code: code};
    r.typed_count = n;
    r.typed_code = tcode;
    r.typed_pressed = tpressed;
    return r;
  endfunction

  // updates the tracked matrix and keymap, optionally queues the predicted changes
  task automatic apply_word(input key_word_t w, input bit push_predicted);
    int slot;
    int n;
    key_change_t ev;
    logic [5:0] old_bits;
    if (w.row >= ROWS) return;
    slot = w.half * ROWS + w.row;
    if (w.op == OP_MAP) begin
      if (w.mcol < COLS) key_codes[slot*COLS + w.mcol] = w.code;
      return;
    end
    old_bits = row_state[slot];
    row_state[slot] = w.bits;
    n = 0;
    for (int c = 0; c < COLS; c++) begin
      if (old_bits[c] != w.bits[c]) begin
        ev.key_code = key_codes[slot*COLS + c];
        ev.pressed = w.bits[c];
        ev.last = 1'b0;
        if (push_predicted) pending_changes.push_back(ev);
        n++;
      end
    end
    if (push_predicted && n > 0) pending_changes[pending_changes.size()-1].last = 1'b1;
  endtask

  task automatic send_word(input key_word_t w);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= w.op;
    s_tdata <= {3'b000, w.code, w.mcol, w.bits, w.row, w.half};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_changes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic key_word_t random_word();
    key_word_t w;
    w.op = ($urandom_range(99) < 30) ? OP_MAP : OP_SCAN;
    w.half = 1'($urandom_range(1));
    w.row = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
    w.bits = 6'($urandom_range(63));
    w.mcol = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
    w.code = 8'($urandom_range(255));
    // some scans repeat the stored row so nothing changes
    if (w.op == OP_SCAN && w.row < ROWS && $urandom_range(99) < 20)
      w.bits = row_state[w.half*ROWS + w.row];
    return w;
  endfunction

  task automatic random_phase(input int count);
    key_word_t w;
    for (int i = 0; i < count; i++) begin
      w = random_word();
      send_word(w);
      apply_word(w, 1'b1);
      @(negedge clk);
    end
    drain();
  endtask

  // receiver side
  initial begin
    m_tready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    key_change_t exp_ev;
    if (!rst && m_tvalid && m_tready) begin
      changes_seen++;
      if (pending_changes.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: key_code=%02h pressed=%0b last=%0b",
                   m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        exp_ev = pending_changes.pop_front();
        if (m_tdata !== exp_ev.key_code || m_tuser !== exp_ev.pressed ||
            m_tlast !== exp_ev.last) begin
          if (errors < 10)
            $display({"mismatch: key_code exp %02h got %02h, pressed exp %0b got %0b, ",
                      "last exp %0b got %0b"},
                     exp_ev.key_code, m_tdata, exp_ev.pressed, m_tuser, exp_ev.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog expired with %0d words outstanding", pending_changes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    key_change_t ev;
    stim_row_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_SCAN;
    words_sent = 0;
    hold_req = 1'b0;
    send_idle = 14;
    recv_idle = 52;
    foreach (row_state[i]) row_state[i] = '0;
    foreach (key_codes[i]) key_codes[i] = '0;

    // after reset every key is up and maps to zero
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd0, 6'h3f, 3'd0, 8'h00, 6, 8'h00, 1'b1));
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd0, 6'h3f, 3'd0, 8'h00, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd0, 6'h00, 3'd0, 8'h00, 6, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b0, 3'd0, 6'h00, 3'd0, 8'hff, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b0, 3'd0, 6'h3f, 3'd5, 8'h80, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b1, 3'd4, 6'h15, 3'd2, 8'ha5, 0, 8'h00, 1'b0));
    // keymap column and row out of range are dropped
    stim_rows.push_back(stim(OP_MAP,  1'b0, 3'd0, 6'h00, 3'd6, 8'h11, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b0, 3'd0, 6'h00, 3'd7, 8'h22, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b0, 3'd5, 6'h00, 3'd0, 8'h33, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b1, 3'd7, 6'h00, 3'd1, 8'h44, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd0, 6'h21, 3'd7, 8'hff, -1, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b1, 3'd4, 6'h04, 3'd0, 8'h00, -1, 8'h00, 1'b0));
    // scans of rows out of range are dropped
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd7, 6'h3f, 3'd0, 8'h00, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b1, 3'd5, 6'h2a, 3'd0, 8'h00, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b1, 3'd6, 6'h15, 3'd0, 8'h00, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b1, 3'd4, 6'h3f, 3'd0, 8'h00, -1, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b1, 3'd4, 6'h00, 3'd1, 8'h00, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_MAP,  1'b1, 3'd4, 6'h00, 3'd3, 8'h5a, 0, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b1, 3'd4, 6'h2a, 3'd0, 8'h00, -1, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b1, 3'd3, 6'h3f, 3'd0, 8'h00, 6, 8'h00, 1'b1));
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd0, 6'h1e, 3'd7, 8'hff, -1, 8'h00, 1'b0));
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd4, 6'h3f, 3'd0, 8'h00, 6, 8'h00, 1'b1));
    stim_rows.push_back(stim(OP_SCAN, 1'b0, 3'd4, 6'h3f, 3'd0, 8'h00, 0, 8'h00, 1'b0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      r = stim_rows[i];
      send_word(r.w);
      apply_word(r.w, r.typed_count < 0);
      for (int k = 0; k < r.typed_count; k++) begin
        ev.key_code = r.typed_code;
        ev.pressed = r.typed_pressed;
        ev.last = (k == r.typed_count - 1);
        pending_changes.push_back(ev);
      end
      @(negedge clk);
    end
    drain();

    random_phase(26);
    send_idle = 52;
    recv_idle = 14;
    random_phase(26);
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    random_phase(25);

    repeat (20) @(posedge clk);
    $display("sent %0d words (%0d directed), checked %0d key change words",
             words_sent, stim_rows.size(), changes_seen);
    $display("covered keymap writes, dropped rows and columns, idle and stall phases");
    if (errors == 0 && pending_changes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, pending_changes.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/kmce_pkg.sv
hdl/kmce_clr_ram.sv
hdl/key_matrix_change_encoder.sv
sim/key_matrix_change_encoder_tb.sv
